// ===== hdl/ffea_pkg.sv =====
// package for the first-fit extent allocator
// shared constants, payload structs and cell control types; no dependencies
`timescale 1ns / 1ps
package ffea_pkg;

   localparam int MAX_EXTENTS = 64;
   localparam int ADDR_BITS   = 32;
   localparam int LEN_BITS    = 32;
   localparam int CNT_BITS    = $clog2(MAX_EXTENTS + 1);
   localparam int IDX_BITS    = $clog2(MAX_EXTENTS);
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   localparam logic [0:0] CSR_REGION_BASE   = 1'b0;
   localparam logic [0:0] CSR_REGION_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef struct packed {
      logic                 func;
      logic [ADDR_BITS-1:0] block_addr;
      logic [LEN_BITS-1:0]  block_size;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_addr;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_APPLY,
      ST_REPLY
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INIT,
      OP_SHIFT_DOWN,
      OP_SHIFT_UP,
      OP_SET_LEN,
      OP_SET_BOTH
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [IDX_BITS-1:0]  pos;
      logic [ADDR_BITS-1:0] start;
      logic [LEN_BITS-1:0]  len;
   } cell_ctl_type;

   function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
   endfunction

endpackage

// ===== hdl/ffea_cell.sv =====
// one extent cell of the sorted chain
// depends on ffea_pkg; takes its neighbours' contents for shifts
`timescale 1ns / 1ps
module ffea_cell (
   input  logic                           clock,
   input  logic [ffea_pkg::IDX_BITS-1:0]  my_idx,
   input  ffea_pkg::cell_ctl_type         ctl,
   input  logic [ffea_pkg::ADDR_BITS-1:0] lo_start,
   input  logic [ffea_pkg::LEN_BITS-1:0]  lo_len,
   input  logic [ffea_pkg::ADDR_BITS-1:0] hi_start,
   input  logic [ffea_pkg::LEN_BITS-1:0]  hi_len,
   output logic [ffea_pkg::ADDR_BITS-1:0] start,
   output logic [ffea_pkg::LEN_BITS-1:0]  len
);
   import ffea_pkg::*;

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      case (ctl.op)
         OP_INIT: begin
            if (my_idx == '0) begin
               start_in = ctl.start;
               len_in   = ctl.len;
            end
         end
         OP_SHIFT_DOWN: begin
            if (my_idx >= ctl.pos) begin
               start_in = hi_start;
               len_in   = hi_len;
            end
         end
         OP_SHIFT_UP: begin
            if (my_idx > ctl.pos) begin
               start_in = lo_start;
               len_in   = lo_len;
            end else if (my_idx == ctl.pos) begin
               start_in = ctl.start;
               len_in   = ctl.len;
            end
         end
         OP_SET_LEN: begin
            if (my_idx == ctl.pos) len_in = ctl.len;
         end
         OP_SET_BOTH: begin
            if (my_idx == ctl.pos) begin
               start_in = ctl.start;
               len_in   = ctl.len;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign start = start_ff;
   assign len   = len_ff;
endmodule

// ===== hdl/ffea_chain.sv =====
// row of extent cells with per-cell compare flags
// depends on ffea_pkg and ffea_cell
`timescale 1ns / 1ps
module ffea_chain (
   input  logic                           clock,
   input  ffea_pkg::cell_ctl_type         ctl,
   input  logic [ffea_pkg::LEN_BITS-1:0]  size,
   input  logic [ffea_pkg::ADDR_BITS-1:0] addr,
   output logic [ffea_pkg::MAX_EXTENTS-1:0] fit_flags,
   output logic [ffea_pkg::MAX_EXTENTS-1:0] above_flags,
   output logic [ffea_pkg::ADDR_BITS-1:0] starts [ffea_pkg::MAX_EXTENTS],
   output logic [ffea_pkg::LEN_BITS-1:0]  lens [ffea_pkg::MAX_EXTENTS]
);
   import ffea_pkg::*;

   for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
      logic [ADDR_BITS-1:0] lo_s, hi_s;
      logic [LEN_BITS-1:0]  lo_l, hi_l;
      if (g == 0) begin : g_lo0
         assign lo_s = '0;
         assign lo_l = '0;
      end else begin : g_lo
         assign lo_s = starts[g-1];
         assign lo_l = lens[g-1];
      end
      if (g == MAX_EXTENTS - 1) begin : g_hiN
         assign hi_s = '0;
         assign hi_l = '0;
      end else begin : g_hi
         assign hi_s = starts[g+1];
         assign hi_l = lens[g+1];
      end
      ffea_cell u_cell (
         .clock    (clock),
         .my_idx   (IDX_BITS'(g)),
         .ctl      (ctl),
         .lo_start (lo_s),
         .lo_len   (lo_l),
         .hi_start (hi_s),
         .hi_len   (hi_l),
         .start    (starts[g]),
         .len      (lens[g])
      );
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_EXTENTS; i++) begin
         fit_flags[i]   <= lens[i] >= size;
         above_flags[i] <= addr < starts[i];
      end
   end
endmodule

// ===== hdl/ffea_ctrl.sv =====
// sequencer: picks first fit or insertion point and drives the cell row
// depends on ffea_pkg
`timescale 1ns / 1ps
module ffea_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ffea_pkg::req_type                req,
   input  logic                             csr_write,
   input  logic [ffea_pkg::ADDR_BITS-1:0]   cfg_base,
   input  logic [ffea_pkg::LEN_BITS-1:0]    cfg_len,
   input  logic [ffea_pkg::MAX_EXTENTS-1:0] fit_flags,
   input  logic [ffea_pkg::MAX_EXTENTS-1:0] above_flags,
   input  logic [ffea_pkg::ADDR_BITS-1:0]   starts [ffea_pkg::MAX_EXTENTS],
   input  logic [ffea_pkg::LEN_BITS-1:0]    lens [ffea_pkg::MAX_EXTENTS],
   output ffea_pkg::cell_ctl_type           ctl,
   output logic [ffea_pkg::LEN_BITS-1:0]    size,
   output logic [ffea_pkg::ADDR_BITS-1:0]   addr,
   output logic                             rsp_valid,
   output ffea_pkg::rsp_type                rsp,
   output logic [ffea_pkg::CNT_BITS-1:0]    count
);
   import ffea_pkg::*;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [LEN_BITS-1:0]  total_ff, total_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic                 hit_ff, hit_in;
   logic                 init_ff, init_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [CNT_BITS-1:0]  first_idx;
   logic                 first_hit;
   logic [IDX_BITS-1:0]  p;
   logic [IDX_BITS-1:0]  pm1;
   logic                 prev_touch, next_touch;
   logic [LEN_BITS-1:0]  new_len;

   // priority pick over the flags of live cells
   always_comb begin
      first_idx = count_ff;
      first_hit = 1'b0;
      for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
         if (CNT_BITS'(i) < count_ff &&
             (req_ff.func == FUNC_ALLOC ? fit_flags[i] : above_flags[i])) begin
            first_idx = CNT_BITS'(i);
            first_hit = 1'b1;
         end
      end
   end

   assign p   = pos_ff[IDX_BITS-1:0];
   assign pm1 = p - 1'b1;

   always_comb begin
      prev_touch = 1'b0;
      next_touch = 1'b0;
      if (pos_ff != '0)
         prev_touch = (starts[pm1] + ADDR_BITS'(lens[pm1])) == req_ff.block_addr;
      if (pos_ff < count_ff)
         next_touch = (req_ff.block_addr + ADDR_BITS'(req_ff.block_size)) == starts[p];
   end

   assign new_len = lens[p] - req_ff.block_size;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      init_in      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ctl          = '{op: OP_HOLD, pos: '0, start: '0, len: '0};
      if (init_ff) begin
         ctl = '{op: OP_INIT, pos: '0, start: cfg_base, len: cfg_len};
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               init_in = 1'b1;
            end else if (start && !init_ff) begin
               req_in   = req;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: state_in = ST_DECIDE;
         ST_DECIDE: begin
            pos_in   = first_idx;
            hit_in   = first_hit;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            rsp_in   = '{granted_addr: '0, status: STATUS_DONE};
            state_in = ST_REPLY;
            if (req_ff.func == FUNC_ALLOC) begin
               if (req_ff.block_size > total_ff || !hit_ff) begin
                  rsp_in.status = STATUS_NOSPACE;
               end else begin
                  total_in = total_ff - req_ff.block_size;
                  rsp_in.granted_addr = 32'(starts[p] + ADDR_BITS'(new_len));
                  if (new_len == '0) begin
                     ctl = '{op: OP_SHIFT_DOWN, pos: p, start: '0, len: '0};
                     count_in = count_ff - 1'b1;
                  end else begin
                     ctl = '{op: OP_SET_LEN, pos: p, start: '0, len: new_len};
                  end
               end
            end else begin
               if (prev_touch && next_touch) begin
                  ctl = '{op: OP_SET_LEN, pos: pm1, start: '0,
                          len: sat_add(sat_add(lens[pm1], req_ff.block_size), lens[p])};
                  state_in = ST_SCAN;
               end else if (prev_touch) begin
                  ctl = '{op: OP_SET_LEN, pos: pm1, start: '0,
                          len: sat_add(lens[pm1], req_ff.block_size)};
               end else if (next_touch) begin
                  ctl = '{op: OP_SET_BOTH, pos: p, start: req_ff.block_addr,
                          len: sat_add(lens[p], req_ff.block_size)};
               end else if (count_ff >= CNT_BITS'(MAX_EXTENTS)) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  ctl = '{op: OP_SHIFT_UP, pos: p, start: req_ff.block_addr,
                          len: req_ff.block_size};
                  count_in = count_ff + 1'b1;
               end
               if (rsp_in.status == STATUS_DONE)
                  total_in = sat_add(total_ff, req_ff.block_size);
               // double merge removes the following cell next cycle
               if (prev_touch && next_touch) begin
                  state_in = ST_REPLY;
                  hit_in   = 1'b1;
               end else begin
                  hit_in   = 1'b0;
               end
            end
         end
         ST_REPLY: begin
            if (req_ff.func == FUNC_FREE && hit_ff) begin
               ctl      = '{op: OP_SHIFT_DOWN, pos: p, start: '0, len: '0};
               count_in = count_ff - 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_BITS'(1);
         total_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= init_ff ? CNT_BITS'(1) : count_in;
         total_ff     <= init_ff ? cfg_len : total_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
      req_ff <= req_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE || init_ff;
   assign size      = req_ff.block_size;
   assign addr      = req_ff.block_addr;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign count     = count_ff;
endmodule

// ===== hdl/first_fit_extent_allocator_unit.sv =====
// Each item runs from start to its rsp_valid strobe through the scan, decide, apply and
// reply states: the cell row registers its compare flags, a priority pick selects the
// first fitting or following extent, and the apply state applies the change; a merge
// on both sides removes the spent cell in the reply cycle. busy stays high meanwhile and
// while an idle register write reloads the table with one extent. Results cannot be stalled.
// depends on ffea_pkg, ffea_ctrl, ffea_chain
`timescale 1ns / 1ps
module first_fit_extent_allocator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffea_pkg::req_type req_data,
   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_data,
   output logic              rsp_valid,
   output ffea_pkg::rsp_type rsp_data
);
   import ffea_pkg::*;

   logic [ADDR_BITS-1:0] base_ff;
   logic [LEN_BITS-1:0]  len_ff;
   cell_ctl_type         ctl;
   logic [LEN_BITS-1:0]  size;
   logic [ADDR_BITS-1:0] addr;
   logic [MAX_EXTENTS-1:0] fit_flags, above_flags;
   logic [ADDR_BITS-1:0] starts [MAX_EXTENTS];
   logic [LEN_BITS-1:0]  lens [MAX_EXTENTS];
   logic [CNT_BITS-1:0]  count;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         len_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_REGION_BASE:   base_ff <= ADDR_BITS'(csr_data);
            CSR_REGION_LENGTH: len_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   ffea_ctrl u_ctrl (
      .clock, .reset, .start, .busy,
      .req         (req_data),
      .csr_write,
      .cfg_base    (base_ff),
      .cfg_len     (len_ff),
      .fit_flags, .above_flags, .starts, .lens,
      .ctl, .size, .addr,
      .rsp_valid,
      .rsp         (rsp_data),
      .count
   );

   ffea_chain u_chain (
      .clock, .ctl, .size, .addr,
      .fit_flags, .above_flags, .starts, .lens
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_BITS'(MAX_EXTENTS)) else $error("extent count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("double result strobe");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for first_fit_extent_allocator_unit
// predicts each reply from a local model of the free extent table; depends on ffea_pkg
`timescale 1ns / 1ps
module tb_top;
   import ffea_pkg::*;

   localparam int TABLE_DEPTH = MAX_EXTENTS;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   req_type  req_data = '0;
   logic     csr_write = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic     rsp_valid;
   rsp_type  rsp_data;

   first_fit_extent_allocator_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // local free table
   logic [31:0] ext_start [TABLE_DEPTH];
   logic [31:0] ext_len [TABLE_DEPTH];
   int          ext_count;
   logic [31:0] free_sum;
   logic [31:0] cfg_base, cfg_len;

   req_type     pending_items[$];
   rsp_type     expected_replies[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          csr_idx_q;
   logic [31:0] csr_val_q;
   logic        csr_req = 1'b0;

   function automatic logic [31:0] len_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void table_reload();
      ext_start[0] = cfg_base;
      ext_len[0] = cfg_len;
      ext_count = 1;
      free_sum = cfg_len;
   endfunction

   function automatic void drop_entry(input int p);
      for (int i = p; i + 1 < ext_count; i++) begin
         ext_start[i] = ext_start[i + 1];
         ext_len[i] = ext_len[i + 1];
      end
      ext_count--;
   endfunction

   function automatic rsp_type predict_reply(input req_type it);
      rsp_type r;
      int p;
      logic prev_hit, next_hit;
      r.granted_addr = '0;
      r.status = STATUS_NOSPACE;
      if (it.func == FUNC_ALLOC) begin
         if (it.block_size <= free_sum) begin
            for (int i = 0; i < ext_count; i++) begin
               if (ext_len[i] >= it.block_size) begin
                  ext_len[i] = ext_len[i] - it.block_size;
                  free_sum = free_sum - it.block_size;
                  r.granted_addr = ext_start[i] + ext_len[i];
                  r.status = STATUS_DONE;
                  if (ext_len[i] == 0) drop_entry(i);
                  break;
               end
            end
         end
         return r;
      end
      p = 0;
      while (p < ext_count && !(it.block_addr < ext_start[p])) p++;
      prev_hit = p > 0 && (ext_start[p-1] + ext_len[p-1]) == it.block_addr;
      next_hit = p < ext_count && (it.block_addr + it.block_size) == ext_start[p];
      r.status = STATUS_DONE;
      if (prev_hit && next_hit) begin
         ext_len[p-1] = len_sat(len_sat(ext_len[p-1], it.block_size), ext_len[p]);
         drop_entry(p);
      end else if (prev_hit) begin
         ext_len[p-1] = len_sat(ext_len[p-1], it.block_size);
      end else if (next_hit) begin
         ext_start[p] = it.block_addr;
         ext_len[p] = len_sat(ext_len[p], it.block_size);
      end else begin
         if (ext_count >= TABLE_DEPTH) begin
            r.status = STATUS_FULL;
            return r;
         end
         for (int i = ext_count; i > p; i--) begin
            ext_start[i] = ext_start[i-1];
            ext_len[i] = ext_len[i-1];
         end
         ext_start[p] = it.block_addr;
         ext_len[p] = it.block_size;
         ext_count++;
      end
      free_sum = len_sat(free_sum, it.block_size);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_write <= 1'b0;
      end else begin
         csr_write <= 1'b0;
         if (csr_req && !csr_write) begin
            csr_write <= 1'b1;
            csr_index <= csr_idx_q[0:0];
            csr_data <= csr_val_q;
            csr_req <= 1'b0;
            if (csr_idx_q == CSR_REGION_BASE) cfg_base = csr_val_q;
            else cfg_len = csr_val_q;
            table_reload();
         end else if (start && busy) begin
            start <= 1'b1;
         end else begin
            if (start) begin
               expected_replies.push_back(predict_reply(req_data));
               void'(pending_items.pop_front());
            end
            if (pending_items.size() > 0 && !csr_req &&
                $urandom_range(99) >= send_idle_pct) begin
               start <= 1'b1;
               req_data <= pending_items[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reply %h", rsp_data);
         end else begin
            rsp_type e;
            e = expected_replies.pop_front();
            if (rsp_data.granted_addr !== e.granted_addr || rsp_data.status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                           e.granted_addr, e.status, rsp_data.granted_addr, rsp_data.status);
            end
         end
      end
   end

   task automatic queue_item(input logic f, input logic [31:0] a, input logic [31:0] s);
      req_type it;
      it.func = f;
      it.block_addr = a;
      it.block_size = s;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || start || expected_replies.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input int idx, input logic [31:0] v);
      @(posedge clock);
      csr_idx_q <= idx;
      csr_val_q <= v;
      csr_req <= 1'b1;
      @(posedge clock);
      while (csr_req || csr_write) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // random mix of allocations and frees within a freshly configured region
   task automatic random_phase(input int n, input logic [31:0] base, input logic [31:0] len,
                               input logic [31:0] max_sz);
      logic [31:0] a, s;
      write_csr(CSR_REGION_BASE, base);
      write_csr(CSR_REGION_LENGTH, len);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: queue_item(FUNC_ALLOC, $urandom, $urandom_range(max_sz));
            4, 5, 6: begin
               s = $urandom_range(max_sz) + 1;
               a = base + $urandom_range(len);
               queue_item(FUNC_FREE, a, s);
            end
            7: queue_item(FUNC_FREE, base + ($urandom_range(len / 8) * 8), 8);
            8: queue_item($urandom_range(1), $urandom, $urandom);
            default: queue_item(FUNC_ALLOC, $urandom, 0);
         endcase
      end
      drain();
   endtask

   initial begin
      cfg_base = '0;
      cfg_len = '0;
      table_reload();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // empty region after reset
      queue_item(FUNC_ALLOC, '0, 0);
      queue_item(FUNC_ALLOC, '1, 1);
      queue_item(FUNC_FREE, 32'h100, 32'h10);
      queue_item(FUNC_ALLOC, '0, 32'h8);
      drain();
      write_csr(CSR_REGION_BASE, 32'hFFFF_FF00);
      write_csr(CSR_REGION_LENGTH, 32'h0000_0200);
      queue_item(FUNC_ALLOC, '0, 32'h100);
      queue_item(FUNC_ALLOC, '0, 32'hFFFF_FFFF);
      queue_item(FUNC_FREE, 32'hFFFF_FF00, 32'h80);
      queue_item(FUNC_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_item(FUNC_ALLOC, '1, 0);
      queue_item(FUNC_ALLOC, '0, 32'h80);
      queue_item(FUNC_FREE, 32'h10, 32'h10);
      queue_item(FUNC_FREE, 32'h30, 32'h10);
      queue_item(FUNC_FREE, 32'h20, 32'h10);
      queue_item(FUNC_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      write_csr(CSR_REGION_BASE, 32'h0);
      write_csr(CSR_REGION_LENGTH, 32'hFFFF_FFFF);
      queue_item(FUNC_FREE, 32'h0, 32'h10);
      queue_item(FUNC_ALLOC, '0, 32'hFFFF_FFFF);
      queue_item(FUNC_ALLOC, '0, 32'h1);
      drain();
      // fill the table to its limit with isolated blocks
      write_csr(CSR_REGION_BASE, 32'h1000);
      write_csr(CSR_REGION_LENGTH, 32'h10);
      for (int i = 0; i < 66; i++) queue_item(FUNC_FREE, 32'h2000 + i * 32, 8);
      queue_item(FUNC_FREE, 32'h1010, 8);
      drain();
      send_idle_pct = 0;
      random_phase(260, 32'h0001_0000, 32'h0000_1000, 64);
      send_idle_pct = 56;
      random_phase(260, 32'hFFFF_F000, 32'h0000_2000, 256);
      send_idle_pct = 56;
      random_phase(260, $urandom, $urandom_range(4096), 32);
      send_idle_pct = 34;
      random_phase(200, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      if (mismatches == 0) $display("** first_fit_extent_allocator_unit: PASSED **");
      else $display("** first_fit_extent_allocator_unit: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** first_fit_extent_allocator_unit: FAILED **");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/ffea_pkg.sv
hdl/ffea_cell.sv
hdl/ffea_chain.sv
hdl/ffea_ctrl.sv
hdl/first_fit_extent_allocator_unit.sv
tb/tb_top.sv
